### rtl/mpfb_pkg.sv
// shared types and constants of the page framebuffer blitter
package mpfb_pkg;

   localparam int DISPLAY_WIDTH_DEF  = 128;
   localparam int DISPLAY_HEIGHT_DEF = 64;
   localparam int QUEUE_DEPTH_DEF    = 2;

   // signed coordinate width, holds origin plus column plus bit offset
   localparam int COORD_W     = 18;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 56;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLIT_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLIT_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLIT_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLIT_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLIT_INK    = 3'd4;

   typedef enum logic [1:0] {
      KIND_PIXEL  = 2'd0,
      KIND_BITMAP = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_PAINT = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_PX_RD,
      B_PX_WR,
      B_RD_ISSUE,
      B_RD_DONE
   } back_state_type;

   // one queued job: a paint of up to eight pixels, a clear or a read
   typedef struct packed {
      op_type                     op;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic [7:0]                 mask;
      logic                       on;
      logic [9:0]                 rd_index;
   } entry_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage

### rtl/mpfb_queue.sv
// short job queue between front and back
module mpfb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mpfb_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output mpfb_pkg::entry_type head
);
   import mpfb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type              slots_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule

### rtl/mpfb_front.sv
// front end: registers, bitmap position tracking and job building
module mpfb_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mpfb_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic [mpfb_pkg::REQ_USER_W-1:0]       req_tuser,
   input  logic                                  csr_we,
   input  logic [mpfb_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mpfb_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  mpfb_pkg::back_status_type             back_status,
   input  logic                                  q_full,
   output logic                                  q_push,
   output mpfb_pkg::entry_type                   q_entry
);
   import mpfb_pkg::*;

   logic signed [15:0] blit_x_ff;
   logic signed [15:0] blit_y_ff;
   logic [7:0]         blit_width_ff;
   logic [7:0]         blit_height_ff;
   logic               blit_ink_ff;
   logic [7:0]         blit_row_ff, blit_row_in;
   logic [4:0]         blit_bcol_ff, blit_bcol_in;

   kind_type           kind;
   logic               bitmap_first;
   logic signed [15:0] pixel_x, pixel_y;
   logic               pixel_on;
   logic [7:0]         bitmap_byte;
   logic [9:0]         read_index;
   logic               accept;

   logic [7:0]         cur_row;
   logic [4:0]         cur_bcol;
   logic [7:0]         col_base;
   logic [7:0]         paint_mask;
   logic [5:0]         byte_width;
   logic [5:0]         bcol_next;

   assign kind         = kind_type'(req_tuser[1:0]);
   assign bitmap_first = req_tuser[2];
   assign pixel_x      = req_tdata[15:0];
   assign pixel_y      = req_tdata[31:16];
   assign pixel_on     = req_tdata[32];
   assign bitmap_byte  = req_tdata[40:33];
   assign read_index   = req_tdata[50:41];

   assign req_tready = !q_full && !back_status.init_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cur_row    = bitmap_first ? '0 : blit_row_ff;
      cur_bcol   = bitmap_first ? '0 : blit_bcol_ff;
      col_base   = {cur_bcol, 3'b000};
      for (int b = 0; b < 8; b++) begin
         paint_mask[7-b] = bitmap_byte[7-b] && (cur_row < blit_height_ff)
            && (({1'b0, col_base} + 9'(b)) < {1'b0, blit_width_ff});
      end
      byte_width = {1'b0, blit_width_ff[7:3]} + 6'(|blit_width_ff[2:0]);
      bcol_next  = {1'b0, cur_bcol} + 6'd1;
      blit_row_in  = blit_row_ff;
      blit_bcol_in = blit_bcol_ff;
      if (accept && kind == KIND_BITMAP) begin
         if (bcol_next >= byte_width) begin
            blit_bcol_in = '0;
            blit_row_in  = (cur_row == 8'hFF) ? cur_row : cur_row + 8'd1;
         end else begin
            blit_bcol_in = bcol_next[4:0];
            blit_row_in  = cur_row;
         end
      end
   end

   always_comb begin
      q_entry.op       = OP_PAINT;
      q_entry.x        = COORD_W'(pixel_x);
      q_entry.y        = COORD_W'(pixel_y);
      q_entry.mask     = 8'h80;
      q_entry.on       = pixel_on;
      q_entry.rd_index = read_index;
      q_push           = accept;
      case (kind)
         KIND_PIXEL: begin
         end
         KIND_BITMAP: begin
            q_entry.x    = COORD_W'(blit_x_ff) + $signed(COORD_W'(col_base));
            q_entry.y    = COORD_W'(blit_y_ff) + $signed(COORD_W'(cur_row));
            q_entry.mask = paint_mask;
            q_entry.on   = blit_ink_ff;
            q_push       = accept && (paint_mask != '0);
         end
         KIND_CLEAR: q_entry.op = OP_CLEAR;
         KIND_READ:  q_entry.op = OP_READ;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blit_x_ff      <= '0;
         blit_y_ff      <= '0;
         blit_width_ff  <= 8'd8;
         blit_height_ff <= 8'd8;
         blit_ink_ff    <= 1'b1;
         blit_row_ff    <= '0;
         blit_bcol_ff   <= '0;
      end else begin
         blit_row_ff  <= blit_row_in;
         blit_bcol_ff <= blit_bcol_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BLIT_X:      blit_x_ff      <= csr_wdata;
               CSR_BLIT_Y:      blit_y_ff      <= csr_wdata;
               CSR_BLIT_WIDTH:  blit_width_ff  <= csr_wdata[7:0];
               CSR_BLIT_HEIGHT: blit_height_ff <= csr_wdata[7:0];
               CSR_BLIT_INK:    blit_ink_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

### rtl/mpfb_back.sv
// back end: frame store, pixel read-modify-write, clear sweep and reads
module mpfb_back #(
   parameter int DISPLAY_WIDTH  = mpfb_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = mpfb_pkg::DISPLAY_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  mpfb_pkg::entry_type                q_head,
   output logic                               q_pop,
   output mpfb_pkg::back_status_type          back_status,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mpfb_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import mpfb_pkg::*;

   localparam int PAGES       = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = DISPLAY_WIDTH * PAGES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam logic signed [COORD_W-1:0] W_S = COORD_W'(DISPLAY_WIDTH);
   localparam logic signed [COORD_W-1:0] H_S = COORD_W'(DISPLAY_HEIGHT);

   logic [7:0]                store_mem [STORE_BYTES];

   back_state_type            state_ff, state_in;
   entry_type                 cur_ff;
   logic [ADDR_W-1:0]         clr_cnt_ff;
   logic [ADDR_W-1:0]         wr_addr_ff;
   logic [7:0]                bit_mask_ff;
   logic                      px_ok_ff;
   logic [7:0]                rd_q_ff;
   logic                      init_busy_ff;
   logic                      rsp_valid_ff;
   logic [7:0]                rsp_data_ff;

   logic [2:0]                sel_b;
   logic signed [COORD_W-1:0] px_x;
   logic                      px_inside;
   logic [ADDR_W-1:0]         px_addr;
   logic                      rd_ok;
   logic                      clr_last;
   logic                      mem_ren, mem_we;
   logic [ADDR_W-1:0]         mem_raddr, mem_waddr;
   logic [7:0]                mem_wdata;
   logic                      rsp_load;

   always_comb begin
      sel_b = '0;
      for (int i = 7; i >= 0; i--) begin
         if (cur_ff.mask[7-i]) begin
            sel_b = 3'(i);
         end
      end
   end

   assign px_x      = cur_ff.x + $signed(COORD_W'(sel_b));
   assign px_inside = (px_x >= 0) && (px_x < W_S) && (cur_ff.y >= 0) && (cur_ff.y < H_S);
   assign px_addr   = ADDR_W'(px_x) + ADDR_W'(cur_ff.y >>> 3) * ADDR_W'(DISPLAY_WIDTH);
   assign rd_ok     = ({22'd0, cur_ff.rd_index} < 32'(STORE_BYTES));
   assign clr_last  = (clr_cnt_ff == ADDR_W'(STORE_BYTES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: if (clr_last) state_in = B_IDLE;
         B_IDLE: begin
            if (q_valid) begin
               case (q_head.op)
                  OP_PAINT: state_in = B_PX_RD;
                  OP_CLEAR: state_in = B_CLEAR;
                  OP_READ:  state_in = B_RD_ISSUE;
                  default:  state_in = B_IDLE;
               endcase
            end
         end
         B_PX_RD:    state_in = B_PX_WR;
         B_PX_WR:    state_in = (cur_ff.mask != '0) ? B_PX_RD : B_IDLE;
         B_RD_ISSUE: state_in = B_RD_DONE;
         B_RD_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = B_IDLE;
         default:    state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = 1'b0;
      mem_ren   = 1'b0;
      mem_we    = 1'b0;
      mem_raddr = ADDR_W'(cur_ff.rd_index);
      mem_waddr = wr_addr_ff;
      mem_wdata = cur_ff.on ? (rd_q_ff | bit_mask_ff) : (rd_q_ff & ~bit_mask_ff);
      rsp_load  = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
         end
         B_IDLE:     q_pop = q_valid;
         B_PX_RD: begin
            mem_ren   = 1'b1;
            mem_raddr = px_addr;
         end
         B_PX_WR:    mem_we = px_ok_ff;
         B_RD_ISSUE: mem_ren = 1'b1;
         B_RD_DONE:  rsp_load = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_ren) begin
         rd_q_ff <= store_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_cnt_ff   <= '0;
         init_busy_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) begin
            clr_cnt_ff <= clr_last ? '0 : clr_cnt_ff + 1'b1;
            if (clr_last) init_busy_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end else if (state_ff == B_PX_RD) begin
         cur_ff.mask[~sel_b] <= 1'b0;
      end
      if (state_ff == B_PX_RD) begin
         wr_addr_ff  <= px_addr;
         bit_mask_ff <= 8'd1 << cur_ff.y[2:0];
         px_ok_ff    <= px_inside;
      end
      if (rsp_load) begin
         rsp_data_ff <= rd_ok ? rd_q_ff : 8'h00;
      end
   end

   assign back_status.init_busy = init_busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_RD_DONE))
      else $error("response without a read");
   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PX_WR) |-> $past(state_ff == B_PX_RD))
      else $error("pixel write without a read");
   a_busy_clearing: assert property (@(posedge clock) disable iff (reset)
      init_busy_ff |-> (state_ff == B_CLEAR && !q_pop))
      else $error("job taken during reset sweep");

endmodule

### rtl/mono_page_framebuffer_blit.sv
// top level of the monochrome page framebuffer blitter
// sequence: a pixel job is queued, popped by the idle back end, then its store
//   byte is read and, if on screen, rewritten (B_PX_RD, B_PX_WR), once per painted
//   pixel of a bitmap byte; reads pass B_RD_ISSUE, B_RD_DONE into the registered
//   response; clears write one store byte per cycle; jobs are popped only in B_IDLE
// reset: store sweep of DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT/8) bytes, req_tready low
//   meanwhile; registers return to x 0, y 0, width 8, height 8, ink 1
module mono_page_framebuffer_blit #(
   parameter int DISPLAY_WIDTH  = mpfb_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = mpfb_pkg::DISPLAY_HEIGHT_DEF,
   parameter int QUEUE_DEPTH    = mpfb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pixel_x[15:0], pixel_y[31:16], pixel_on[32], bitmap_byte[40:33],
   // read_index[50:41], zero fill above
   input  logic [mpfb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind[1:0], bitmap_first[2]
   input  logic [mpfb_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_data[7:0]
   output logic [mpfb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [mpfb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mpfb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mpfb_pkg::*;

   // jobs travel front -> queue -> back; the front decodes, holds the blit registers
   // and tracks the bitmap position, the back owns the store
   back_status_type back_status;
   logic            q_full, q_push, q_pop, q_valid;
   entry_type       q_entry, q_head;

   mpfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .back_status (back_status),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   // decouples transfer acceptance from the multi-cycle store work
   mpfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   // store read-modify-write, clear sweep and the registered response
   mpfb_back #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .back_status (back_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
